// ----- hdl/dlr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared widths, constants and controller/datapath interface types for the
// DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int POS_BITS    = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS   = FRAC_BITS + 2;
    localparam int QUO_BITS    = FRAC_BITS + 1;
    localparam int CNT_BITS    = COORD_BITS + 1;
    localparam int ITER_BITS   = $clog2(QUO_BITS);
    localparam int WIDTH_BITS  = 11;
    localparam int ADDR_BITS   = 20;
    localparam int COLOR_BITS  = 32;
    localparam int IN_BITS     = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_BYTES    = (IN_BITS + 7) / 8;
    localparam int OUT_BITS    = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1024);
    localparam logic [COORD_BITS-1:0] COORD_MAX   = {COORD_BITS{1'b1}};
    localparam logic [POS_BITS:0]     HALF_UNIT   = (POS_BITS + 1)'(1) << (FRAC_BITS - 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROUND,
        ST_ADDR
    } dlr_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic advance;
        logic round;
        logic out_load;
    } dlr_cmd_t;

    typedef struct packed {
        logic zero_len;
        logic div_last;
        logic active;
        logic out_free;
    } dlr_status_t;

endpackage

// ----- hdl/dda_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer producing frame buffer pixel writes.
// ----------------------------------------------------------------------------
// A load word (tuser 0) takes the endpoints and colour and yields the first
// pixel; each step word (tuser 1) yields the next pixel until the end point,
// which carries tlast. A step word with no line in progress is taken and
// yields nothing. A load passes from acceptance through taking the word, the
// restoring divider that forms both per-step increments one quotient bit a
// cycle, rounding and the address multiply-add; a line with equal endpoints
// skips the divide iterations. A step passes through accept and accumulate,
// round and address.
// The input is taken again as soon as the result sits in the output register.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata: start_x, start_y, end_x, end_y, line_color (lowest bit up)
    input  logic [dlr_pkg::IN_BYTES*8-1:0]       s_axis_tdata,
    // tuser: opcode
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_address, pixel_color (lowest bit up)
    output logic [dlr_pkg::OUT_BYTES*8-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [dlr_pkg::WIDTH_BITS-1:0]       cfg_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready
);

    localparam int CB = dlr_pkg::COORD_BITS;

    dlr_pkg::dlr_cmd_t    cmd;
    dlr_pkg::dlr_status_t status;

    logic [CB-1:0]                   pixel_x, pixel_y;
    logic [dlr_pkg::ADDR_BITS-1:0]   pixel_address;
    logic [dlr_pkg::COLOR_BITS-1:0]  pixel_color;

    assign cfg_ready = 1'b1;

    dlr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dlr_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_x       (s_axis_tdata[CB-1:0]),
        .start_y       (s_axis_tdata[2*CB-1:CB]),
        .end_x         (s_axis_tdata[3*CB-1:2*CB]),
        .end_y         (s_axis_tdata[4*CB-1:3*CB]),
        .line_color    (s_axis_tdata[4*CB+dlr_pkg::COLOR_BITS-1:4*CB]),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_width     (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (m_axis_tlast)
    );

    assign m_axis_tdata = (dlr_pkg::OUT_BYTES*8)'({pixel_color, pixel_address,
                                                   pixel_y, pixel_x});

endmodule

// ----- hdl/dlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlr_ctrl
// Sequencer for the rasterizer: input handshake, divide iterations, rounding
// and output register load.
// ----------------------------------------------------------------------------
module dlr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_opcode,
    output logic                 in_ready,
    input  dlr_pkg::dlr_status_t status,
    output dlr_pkg::dlr_cmd_t    cmd
);

    dlr_pkg::dlr_state_t state_reg;
    dlr_pkg::dlr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == dlr_pkg::OP_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        state_next = dlr_pkg::ST_DIVIDE;
                    end
                    else if (status.active)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = dlr_pkg::ST_ROUND;
                    end
                    // drop a step word with no line in progress
                end
            end
            dlr_pkg::ST_DIVIDE:
            begin
                if (status.zero_len)
                begin
                    state_next = dlr_pkg::ST_ROUND;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                    begin
                        state_next = dlr_pkg::ST_ROUND;
                    end
                end
            end
            dlr_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = dlr_pkg::ST_ADDR;
            end
            dlr_pkg::ST_ADDR:
            begin
                // hold until the output register can take the word
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = dlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/dlr_datapath.sv -----
// ----------------------------------------------------------------------------
// dlr_datapath
// Increment dividers, position accumulators, coordinate rounding, address
// multiply-add and the output register.
// ----------------------------------------------------------------------------
module dlr_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dlr_pkg::COORD_BITS-1:0]      start_x,
    input  logic [dlr_pkg::COORD_BITS-1:0]      start_y,
    input  logic [dlr_pkg::COORD_BITS-1:0]      end_x,
    input  logic [dlr_pkg::COORD_BITS-1:0]      end_y,
    input  logic [dlr_pkg::COLOR_BITS-1:0]      line_color,
    input  logic                                cfg_write,
    input  logic [dlr_pkg::WIDTH_BITS-1:0]      cfg_width,
    input  dlr_pkg::dlr_cmd_t                   cmd,
    output dlr_pkg::dlr_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dlr_pkg::COORD_BITS-1:0]      pixel_x,
    output logic [dlr_pkg::COORD_BITS-1:0]      pixel_y,
    output logic [dlr_pkg::ADDR_BITS-1:0]       pixel_address,
    output logic [dlr_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                last_pixel
);

    localparam int CB = dlr_pkg::COORD_BITS;
    localparam int FB = dlr_pkg::FRAC_BITS;
    localparam int PB = dlr_pkg::POS_BITS;
    localparam int SB = dlr_pkg::STEP_BITS;
    localparam int QB = dlr_pkg::QUO_BITS;
    localparam int NB = dlr_pkg::CNT_BITS;
    localparam int IB = dlr_pkg::ITER_BITS;
    localparam int WB = dlr_pkg::WIDTH_BITS;
    localparam int AB = dlr_pkg::ADDR_BITS;
    localparam int MB = WB + CB;

    // ---- registers ----------------------------------------------------------
    logic [WB-1:0]         width_reg;
    logic [PB-1:0]         pos_x_reg, pos_x_next;
    logic [PB-1:0]         pos_y_reg, pos_y_next;
    logic [SB-1:0]         step_x_reg, step_x_next;
    logic [SB-1:0]         step_y_reg, step_y_next;
    logic [NB-1:0]         steps_reg, steps_next;
    logic [dlr_pkg::COLOR_BITS-1:0] color_reg;
    logic                  active_reg, active_next;
    logic                  last_reg, last_next;
    logic [CB-1:0]         len_reg;
    logic                  neg_x_reg, neg_y_reg;
    logic [CB:0]           rem_x_reg, rem_x_next;
    logic [CB:0]           rem_y_reg, rem_y_next;
    logic [QB-1:0]         bits_x_reg, bits_x_next;
    logic [QB-1:0]         bits_y_reg, bits_y_next;
    logic [QB-1:0]         quo_x_reg, quo_x_next;
    logic [QB-1:0]         quo_y_reg, quo_y_next;
    logic [IB-1:0]         iter_reg, iter_next;
    logic [CB-1:0]         coord_x_reg, coord_y_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [CB-1:0]         out_x_reg, out_y_reg;
    logic [AB-1:0]         out_addr_reg;
    logic [dlr_pkg::COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg;

    // ---- load geometry --------------------------------------------------------
    logic [CB:0]   dx, dy;
    logic [CB-1:0] ax, ay, len_in;

    assign dx     = {1'b0, end_x} - {1'b0, start_x};
    assign dy     = {1'b0, end_y} - {1'b0, start_y};
    assign ax     = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    assign ay     = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    assign len_in = (ax >= ay) ? ax : ay;

    // ---- restoring divide, one quotient bit a cycle per axis ------------------
    logic [CB+1:0] trial_x, trial_y;
    logic          ge_x, ge_y;
    logic [QB-1:0] q_x_final, q_y_final;

    assign trial_x   = {rem_x_reg, bits_x_reg[QB-1]} - {2'b00, len_reg};
    assign trial_y   = {rem_y_reg, bits_y_reg[QB-1]} - {2'b00, len_reg};
    assign ge_x      = !trial_x[CB+1];
    assign ge_y      = !trial_y[CB+1];
    assign q_x_final = {quo_x_reg[QB-2:0], ge_x};
    assign q_y_final = {quo_y_reg[QB-2:0], ge_y};

    // ---- rounding (half up) and clamp -----------------------------------------
    logic [PB:0]   round_x, round_y;
    logic [PB-FB:0] int_x, int_y;
    logic [CB-1:0] clamp_x, clamp_y;

    assign round_x = {pos_x_reg[PB-1], pos_x_reg} + dlr_pkg::HALF_UNIT;
    assign round_y = {pos_y_reg[PB-1], pos_y_reg} + dlr_pkg::HALF_UNIT;
    assign int_x   = round_x[PB:FB];
    assign int_y   = round_y[PB:FB];

    always_comb
    begin
        if (round_x[PB])
            clamp_x = '0;
        else if (int_x > {{(PB-FB+1-CB){1'b0}}, dlr_pkg::COORD_MAX})
            clamp_x = dlr_pkg::COORD_MAX;
        else
            clamp_x = int_x[CB-1:0];
        if (round_y[PB])
            clamp_y = '0;
        else if (int_y > {{(PB-FB+1-CB){1'b0}}, dlr_pkg::COORD_MAX})
            clamp_y = dlr_pkg::COORD_MAX;
        else
            clamp_y = int_y[CB-1:0];
    end

    logic [MB-1:0] addr_full;
    assign addr_full = MB'(width_reg) * MB'(coord_y_reg) + MB'(coord_x_reg);

    // ---- next state -----------------------------------------------------------
    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        steps_next     = steps_reg;
        active_next    = active_reg;
        last_next      = last_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        bits_x_next    = bits_x_reg;
        bits_y_next    = bits_y_reg;
        quo_x_next     = quo_x_reg;
        quo_y_next     = quo_y_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            pos_x_next  = {1'b0, start_x, {FB{1'b0}}};
            pos_y_next  = {1'b0, start_y, {FB{1'b0}}};
            step_x_next = '0;
            step_y_next = '0;
            steps_next  = NB'(len_in);
            active_next = (len_in != '0);
            last_next   = (len_in == '0);
            // N = mag << FB; top bits of the quotient are zero since mag <= len
            rem_x_next  = {1'b0, 1'b0, ax[CB-1:1]};
            rem_y_next  = {1'b0, 1'b0, ay[CB-1:1]};
            bits_x_next = {ax[0], {(QB-1){1'b0}}};
            bits_y_next = {ay[0], {(QB-1){1'b0}}};
            quo_x_next  = '0;
            quo_y_next  = '0;
            iter_next   = '0;
        end

        if (cmd.div_step)
        begin
            rem_x_next  = ge_x ? trial_x[CB:0] : {rem_x_reg[CB-1:0], bits_x_reg[QB-1]};
            rem_y_next  = ge_y ? trial_y[CB:0] : {rem_y_reg[CB-1:0], bits_y_reg[QB-1]};
            bits_x_next = {bits_x_reg[QB-2:0], 1'b0};
            bits_y_next = {bits_y_reg[QB-2:0], 1'b0};
            quo_x_next  = q_x_final;
            quo_y_next  = q_y_final;
            iter_next   = iter_reg + IB'(1);
            if (status.div_last)
            begin
                step_x_next = neg_x_reg ? SB'(-{1'b0, q_x_final}) : {1'b0, q_x_final};
                step_y_next = neg_y_reg ? SB'(-{1'b0, q_y_final}) : {1'b0, q_y_final};
            end
        end

        if (cmd.advance)
        begin
            pos_x_next  = pos_x_reg + {{(PB-SB){step_x_reg[SB-1]}}, step_x_reg};
            pos_y_next  = pos_y_reg + {{(PB-SB){step_y_reg[SB-1]}}, step_y_reg};
            steps_next  = steps_reg - NB'(1);
            active_next = (steps_reg != NB'(1));
            last_next   = (steps_reg == NB'(1));
        end

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // ---- control state --------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= dlr_pkg::WIDTH_RESET;
            active_reg    <= 1'b0;
            steps_reg     <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                width_reg <= cfg_width;
            active_reg    <= active_next;
            steps_reg     <= steps_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---- payload --------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
        last_reg   <= last_next;
        rem_x_reg  <= rem_x_next;
        rem_y_reg  <= rem_y_next;
        bits_x_reg <= bits_x_next;
        bits_y_reg <= bits_y_next;
        quo_x_reg  <= quo_x_next;
        quo_y_reg  <= quo_y_next;
        if (cmd.load)
        begin
            color_reg <= line_color;
            len_reg   <= len_in;
            neg_x_reg <= dx[CB];
            neg_y_reg <= dy[CB];
        end
        if (cmd.round)
        begin
            coord_x_reg <= clamp_x;
            coord_y_reg <= clamp_y;
        end
        if (cmd.out_load)
        begin
            out_x_reg     <= coord_x_reg;
            out_y_reg     <= coord_y_reg;
            out_addr_reg  <= addr_full[AB-1:0];
            out_color_reg <= color_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign status.zero_len = (len_reg == '0);
    assign status.div_last = (iter_reg == IB'(QB - 1));
    assign status.active   = active_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign last_pixel    = out_last_reg;

endmodule

// ----- test/tb_dda_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Self-checking bench for the DDA line rasterizer: a queue-fed driver sends
// load and step words, a fixed-point tracer predicts each pixel write and a
// monitor checks every returned word, across several row pitches and idling
// mixes on both stream sides.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS   = dlr_pkg::COORD_BITS;
    localparam int FRAC_BITS    = dlr_pkg::FRAC_BITS;
    localparam int ADDR_BITS    = dlr_pkg::ADDR_BITS;
    localparam int COLOR_BITS   = dlr_pkg::COLOR_BITS;
    localparam int WIDTH_BITS   = dlr_pkg::WIDTH_BITS;
    localparam int IN_BYTES     = dlr_pkg::IN_BYTES;
    localparam int OUT_BYTES    = dlr_pkg::OUT_BYTES;

    localparam int HALF_PERIOD  = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_QUOTA  = 180;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [COLOR_BITS-1:0] color;
        logic [COORD_BITS-1:0] ey;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] sx;
    } line_fields_t;

    typedef struct packed {
        logic         op;
        line_fields_t f;
    } line_word_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] color;
        logic [ADDR_BITS-1:0]  addr;
        logic [COORD_BITS-1:0] py;
        logic [COORD_BITS-1:0] px;
    } pixel_fields_t;

    typedef struct packed {
        logic          last;
        pixel_fields_t f;
    } pixel_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic [IN_BYTES*8-1:0]      s_axis_tdata = '0;
    logic                       s_axis_tuser = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [OUT_BYTES*8-1:0]     m_axis_tdata;
    logic                       m_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [WIDTH_BITS-1:0]      cfg_data = '0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;

    line_word_t  words_to_send[$];
    pixel_word_t pixels_due[$];
    line_word_t  word_on_bus;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    // tracer state
    logic [WIDTH_BITS-1:0] row_pitch = dlr_pkg::WIDTH_RESET;
    longint                pen_x = 0;
    longint                pen_y = 0;
    int                    inc_x = 0;
    int                    inc_y = 0;
    int                    steps_left = 0;
    logic [COLOR_BITS-1:0] pen_color = '0;
    bit                    drawing = 1'b0;

    dda_line_rasterizer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // round half up, clamped to the coordinate range
    function automatic logic [COORD_BITS-1:0] snap_coord(input longint pos);
        longint r;
        longint c;
        r = pos + (longint'(1) <<< (FRAC_BITS - 1));
        if (r < 0)
            return '0;
        c = r >>> FRAC_BITS;
        if (c > longint'(dlr_pkg::COORD_MAX))
            return dlr_pkg::COORD_MAX;
        return c[COORD_BITS-1:0];
    endfunction

    function automatic int slope(input int d, input int span);
        int mag;
        int q;
        mag = (d < 0) ? -d : d;
        q = (mag <<< FRAC_BITS) / span;
        return (d < 0) ? -q : q;
    endfunction

    task automatic plot_pixel(input bit last);
        pixel_word_t p;
        longint      a;
        p.last = last;
        p.f.px = snap_coord(pen_x);
        p.f.py = snap_coord(pen_y);
        a = longint'(row_pitch) * longint'(p.f.py) + longint'(p.f.px);
        p.f.addr = a[ADDR_BITS-1:0];
        p.f.color = pen_color;
        pixels_due.push_back(p);
    endtask

    task automatic trace_pixel(input line_word_t w);
        int dx;
        int dy;
        int ax;
        int ay;
        int span;
        if (w.op == dlr_pkg::OP_LOAD)
        begin
            dx = int'(w.f.ex) - int'(w.f.sx);
            dy = int'(w.f.ey) - int'(w.f.sy);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            span = (ax >= ay) ? ax : ay;
            pen_color = w.f.color;
            pen_x = longint'(w.f.sx) <<< FRAC_BITS;
            pen_y = longint'(w.f.sy) <<< FRAC_BITS;
            if (span == 0)
            begin
                inc_x = 0;
                inc_y = 0;
                steps_left = 0;
                drawing = 1'b0;
                plot_pixel(1'b1);
            end
            else
            begin
                inc_x = slope(dx, span);
                inc_y = slope(dy, span);
                steps_left = span;
                drawing = 1'b1;
                plot_pixel(1'b0);
            end
        end
        else if (drawing)
        begin
            pen_x += inc_x;
            pen_y += inc_y;
            steps_left--;
            if (steps_left == 0)
            begin
                drawing = 1'b0;
                plot_pixel(1'b1);
            end
            else
                plot_pixel(1'b0);
        end
    endtask

    // driver: predict on acceptance, then offer the next word or idle
    always @(posedge clk)
    begin : drive
        line_word_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                trace_pixel(word_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = words_to_send.pop_front();
                    word_on_bus = nxt;
                    s_axis_tdata <= nxt.f;
                    s_axis_tuser <= nxt.op;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin : watch
        pixel_word_t got;
        pixel_word_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.last = m_axis_tlast;
            got.f = m_axis_tdata[$bits(pixel_fields_t)-1:0];
            if (pixels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected pixel word: x=%0d y=%0d addr=%0d color=%h last=%0b",
                             got.f.px, got.f.py, got.f.addr, got.f.color, got.last);
            end
            else
            begin
                want = pixels_due.pop_front();
                if (got.f.px !== want.f.px || got.f.py !== want.f.py
                    || got.f.addr !== want.f.addr || got.f.color !== want.f.color
                    || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch: expected x=%0d y=%0d addr=%0d color=%h last=%0b",
                                 want.f.px, want.f.py, want.f.addr, want.f.color, want.last);
                        $display("          got x=%0d y=%0d addr=%0d color=%h last=%0b",
                                 got.f.px, got.f.py, got.f.addr, got.f.color, got.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_dda_line_rasterizer failed");
            $finish;
        end
    end

    function automatic int clamp_coord(input int c);
        if (c < 0)
            return 0;
        if (c > int'(dlr_pkg::COORD_MAX))
            return int'(dlr_pkg::COORD_MAX);
        return c;
    endfunction

    function automatic int near(input int c, input int reach);
        return clamp_coord(c + int'($urandom_range(2 * reach)) - reach);
    endfunction

    task automatic queue_step();
        line_word_t  w;
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        w.op = dlr_pkg::OP_STEP;
        w.f = r[$bits(line_fields_t)-1:0];
        words_to_send.push_back(w);
    endtask

    // load plus n steps; made counts the words that yield a pixel
    task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                              input logic [COLOR_BITS-1:0] color, input int n,
                              inout int made);
        line_word_t w;
        int         span;
        span = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > span)
            span = (ey > sy ? ey - sy : sy - ey);
        w.op = dlr_pkg::OP_LOAD;
        w.f.sx = sx[COORD_BITS-1:0];
        w.f.sy = sy[COORD_BITS-1:0];
        w.f.ex = ex[COORD_BITS-1:0];
        w.f.ey = ey[COORD_BITS-1:0];
        w.f.color = color;
        words_to_send.push_back(w);
        repeat (n)
            queue_step();
        made += 1 + ((n < span) ? n : span);
    endtask

    task automatic settle();
        while (words_to_send.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_pitch(input logic [WIDTH_BITS-1:0] v);
        @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        row_pitch = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_lines(input int quota);
        int made;
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int n;
        int pick;
        made = 0;
        while (made < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                queue_step();
                continue;
            end
            sx = $urandom_range(1023);
            sy = $urandom_range(1023);
            if (pick < 8)
            begin
                ex = sx;
                ey = sy;
            end
            else if (pick < 83)
            begin
                ex = near(sx, 12);
                ey = near(sy, 12);
            end
            else if (pick < 96)
            begin
                ex = near(sx, 100);
                ey = near(sy, 100);
            end
            else
            begin
                ex = $urandom_range(1023);
                ey = $urandom_range(1023);
            end
            span = (ex > sx ? ex - sx : sx - ex);
            if ((ey > sy ? ey - sy : sy - ey) > span)
                span = (ey > sy ? ey - sy : sy - ey);
            pick = $urandom_range(99);
            if (pick < 70)
                n = span;
            else if (pick < 90)
                n = $urandom_range(span);
            else
                n = span + $urandom_range(1, 3);
            // keep long lines short of their end
            if (n > 120)
                n = $urandom_range(60);
            queue_line(sx, sy, ex, ey, $urandom, n, made);
        end
    endtask

    int send_mix[4] = '{0, 45, 0, 25};
    int recv_mix[4] = '{0, 0, 45, 25};
    int pitch_set[6] = '{1, 2047, 0, 640, 1024, 0};

    initial
    begin : stimulus
        int made;
        made = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines at the reset row pitch, no idling
        queue_step();
        queue_line(0, 0, 0, 0, 32'h0000_0000, 0, made);
        queue_line(1023, 1023, 1023, 1023, 32'hFFFF_FFFF, 0, made);
        queue_line(0, 0, 2, 1, 32'hA5A5_A5A5, 2, made);
        queue_step();
        queue_line(1023, 0, 1020, 1023, 32'h5A5A_5A5A, 3, made);
        queue_line(5, 9, 0, 4, 32'h1234_5678, 5, made);
        queue_line(0, 1023, 1023, 0, 32'h8000_0001, 2, made);
        queue_line(3, 3, 4, 3, 32'hDEAD_BEEF, 1, made);
        queue_step();
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                write_row_pitch(WIDTH_BITS'($urandom_range(1, 2047)));
            else
                write_row_pitch(WIDTH_BITS'(pitch_set[ph]));
            send_idle_pct = send_mix[ph % 4];
            recv_stall_pct = recv_mix[ph % 4];
            random_lines(PHASE_QUOTA);
            settle();
        end

        if (mismatches == 0)
            $display("tb_dda_line_rasterizer passed");
        else
            $display("tb_dda_line_rasterizer failed");
        $finish;
    end

endmodule
